### rtl/kmsr_pkg.sv
package kmsr_pkg;

  localparam int MAX_ROWS  = 18;
  localparam int ROW_IDX_W = $clog2(MAX_ROWS);
  // one bit wider so that it can also hold the row count itself
  localparam int ROW_CNT_W = ROW_IDX_W + 1;
  localparam int ROW_W     = 8;
  // ram word: key row, latched new row, latched old row
  localparam int WORD_W    = 3 * ROW_W;

  localparam logic [ROW_W-1:0] ROW_IDLE        = 8'hFF;
  localparam int               CTRL_ENABLE_BIT = 7;
  localparam int               SCAN_RD_STATE   = 0;
  localparam logic [1:0]       EVENTS_MAX      = 2'd3;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_KEY   = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    REG_CTRL = 3'd0,
    REG_SCAN = 3'd1,
    REG_NEW  = 3'd2,
    REG_OLD  = 3'd3
  } reg_e;

  typedef enum logic [2:0] {
    ERR_OK            = 3'd0,
    ERR_BURST_END     = 3'd1,
    ERR_EN_MID_BURST  = 3'd2,
    ERR_SCAN_RD_STATE = 3'd3,
    ERR_BAD_REG       = 3'd4,
    ERR_KEY_RANGE     = 3'd5
  } err_e;

  typedef struct packed {
    logic                 rd_en;
    logic [ROW_IDX_W-1:0] rd_addr;
    logic                 wr_en;
    logic [ROW_IDX_W-1:0] wr_addr;
    logic [WORD_W-1:0]    wr_data;
  } ram_req_t;

  typedef struct packed {
    ram_req_t ram;
    logic     done;
  } sweep_t;

  function automatic logic [4:0] drive_count(input logic [2:0] code);
    logic [4:0] cnt;
    case (code)
      3'd0:    cnt = 5'd5;
      3'd1:    cnt = 5'd6;
      3'd2:    cnt = 5'd7;
      3'd3:    cnt = 5'd8;
      3'd4:    cnt = 5'd10;
      3'd5:    cnt = 5'd12;
      3'd6:    cnt = 5'd15;
      default: cnt = 5'd18;
    endcase
    return cnt;
  endfunction

  function automatic logic [3:0] sense_count(input logic [1:0] code);
    logic [3:0] cnt;
    case (code)
      2'd0:    cnt = 4'd5;
      2'd1:    cnt = 4'd6;
      2'd2:    cnt = 4'd7;
      default: cnt = 4'd8;
    endcase
    return cnt;
  endfunction

endpackage

### rtl/kmsr_ram.sv
module kmsr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/kmsr_sweep.sv
module kmsr_sweep (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  // row word as read in the previous cycle, with unwritten rows already shown idle
  input  logic [kmsr_pkg::WORD_W-1:0]      rd_word_i,
  output kmsr_pkg::sweep_t                 sweep_o
);

  localparam logic [kmsr_pkg::ROW_CNT_W-1:0] RowsC =
    kmsr_pkg::ROW_CNT_W'(kmsr_pkg::MAX_ROWS);

  logic                              active_q, active_d;
  logic [kmsr_pkg::ROW_CNT_W-1:0]    cnt_q, cnt_d;
  logic                              wr_pend_q, wr_pend_d;
  logic [kmsr_pkg::ROW_IDX_W-1:0]    wr_idx_q, wr_idx_d;
  logic                              rd_en;
  logic [kmsr_pkg::ROW_W-1:0]        key_row;
  logic [kmsr_pkg::ROW_W-1:0]        new_row;

  assign key_row = rd_word_i[3*kmsr_pkg::ROW_W-1:2*kmsr_pkg::ROW_W];
  assign new_row = rd_word_i[2*kmsr_pkg::ROW_W-1:kmsr_pkg::ROW_W];
  assign rd_en   = active_q && (cnt_q < RowsC);

  always_comb begin
    sweep_o.ram.rd_en   = rd_en;
    sweep_o.ram.rd_addr = cnt_q[kmsr_pkg::ROW_IDX_W-1:0];
    sweep_o.ram.wr_en   = wr_pend_q;
    sweep_o.ram.wr_addr = wr_idx_q;
    // old takes new, new takes the current key row
    sweep_o.ram.wr_data = {key_row, key_row, new_row};
    sweep_o.done        = active_q && !rd_en && wr_pend_q;
  end

  always_comb begin
    active_d  = active_q;
    cnt_d     = cnt_q;
    wr_pend_d = rd_en;
    wr_idx_d  = wr_idx_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
    end else if (sweep_o.done) begin
      active_d = 1'b0;
    end
    if (rd_en) begin
      cnt_d    = cnt_q + 1'b1;
      wr_idx_d = cnt_q[kmsr_pkg::ROW_IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      cnt_q     <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      active_q  <= active_d;
      cnt_q     <= cnt_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_idx_q <= wr_idx_d;
  end

endmodule

### rtl/keypad_matrix_scan_registers.sv
// Keypad matrix scanner with control, scan, new-data and old-data byte registers.
// Each input beat is a register read, a register write, a key event or an unknown
// request type, and each gives exactly one result beat. Key, latched-new and
// latched-old rows share one ram word per drive row; an item is a ram read, then a
// modify and write back. A key change while enabled also captures all rows: a
// sweep through the ram, one row read and one written each cycle, holds the input
// off until it ends. The result beat is registered; the next item is taken only
// once the last is done and that register is empty or is being read out.
module keypad_matrix_scan_registers (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // req_type[1:0], reg_sel[4:2], write_data[12:5], drive_line[17:13],
  // sense_line[20:18], key_down[21], zero[23:22]
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_data[7:0], irq_pulse[8], error_code[11:9], zero[15:12]
  output logic [15:0] m_axis_tdata_o
);

  localparam int RW = kmsr_pkg::ROW_W;
  localparam int IW = kmsr_pkg::ROW_IDX_W;
  localparam int CW = kmsr_pkg::ROW_CNT_W;
  localparam logic [CW-1:0] RowsC = CW'(kmsr_pkg::MAX_ROWS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_SWEEP = 3'b100
  } state_e;

  state_e state_q, state_d;

  // request as taken
  kmsr_pkg::req_e req_q;
  logic [2:0]     reg_q;
  logic [7:0]     wd_q;
  logic [4:0]     drv_q;
  logic [2:0]     sns_q;
  logic           down_q;

  // architectural registers, control stored without its low two bits
  logic [7:2]     ctrl_q, ctrl_d;
  logic [7:0]     scan_q, scan_d;
  logic [1:0]     ev_q, ev_d;
  logic [IW-1:0]  nrow_q, nrow_d;
  logic [IW-1:0]  orow_q, orow_d;

  logic [kmsr_pkg::MAX_ROWS-1:0] valid_q;
  logic [IW-1:0]  rd_addr_q;

  logic           m_valid_q;
  logic [15:0]    m_data_q;

  logic           s_accept;
  logic           exec;
  logic [1:0]     in_req;
  logic [2:0]     in_reg;
  logic [IW-1:0]  acc_addr;
  logic           acc_rd_en;

  kmsr_pkg::ram_req_t ram_req;
  kmsr_pkg::sweep_t   sweep;
  logic [kmsr_pkg::WORD_W-1:0] ram_rdata;
  logic [kmsr_pkg::WORD_W-1:0] rd_word;

  logic [4:0]     drive_cnt;
  logic [3:0]     sense_cnt;
  logic           enabled;
  logic [RW-1:0]  key_row, new_row, old_row;
  logic [RW-1:0]  mask, key_after;
  logic           key_ok;
  logic [IW-1:0]  port_row;
  logic [RW-1:0]  port_field;
  logic [CW-1:0]  port_next;

  logic [7:0]          res_rd;
  logic                res_irq;
  kmsr_pkg::err_e      res_err;
  logic                ex_wr_en;
  logic                capture;

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready_i);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign exec            = (state_q == ST_EXEC);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  assign in_req = s_axis_tdata_i[1:0];
  assign in_reg = s_axis_tdata_i[4:2];

  // ram read address chosen at the accept edge so the data is there in the execute state
  always_comb begin
    acc_addr = s_axis_tdata_i[17:13];
    if (in_req == kmsr_pkg::REQ_READ && in_reg == kmsr_pkg::REG_NEW) begin
      acc_addr = nrow_q;
    end else if (in_req == kmsr_pkg::REQ_READ && in_reg == kmsr_pkg::REG_OLD) begin
      acc_addr = orow_q;
    end
    acc_rd_en = s_accept && ({1'b0, acc_addr} < RowsC);
  end

  // rows never written read as idle
  assign rd_word = valid_q[rd_addr_q] ? ram_rdata : {3{kmsr_pkg::ROW_IDLE}};
  assign key_row = rd_word[3*RW-1:2*RW];
  assign new_row = rd_word[2*RW-1:RW];
  assign old_row = rd_word[RW-1:0];

  assign drive_cnt = kmsr_pkg::drive_count(ctrl_q[4:2]);
  assign sense_cnt = kmsr_pkg::sense_count(ctrl_q[6:5]);
  assign enabled   = ctrl_q[kmsr_pkg::CTRL_ENABLE_BIT];

  assign mask      = RW'(1) << sns_q;
  assign key_after = down_q ? (key_row & ~mask) : (key_row | mask);
  assign key_ok    = ({1'b0, drv_q} < {1'b0, drive_cnt}) && ({1'b0, sns_q} < sense_cnt) &&
                     (CW'(drv_q) < RowsC);

  assign port_row   = (reg_q == kmsr_pkg::REG_NEW) ? nrow_q : orow_q;
  assign port_field = ({1'b0, port_row} >= RowsC) ? kmsr_pkg::ROW_IDLE :
                      (reg_q == kmsr_pkg::REG_NEW) ? new_row : old_row;
  assign port_next  = {1'b0, port_row} + 1'b1;

  always_comb begin
    res_rd   = '0;
    res_irq  = 1'b0;
    res_err  = kmsr_pkg::ERR_OK;
    ctrl_d   = ctrl_q;
    scan_d   = scan_q;
    ev_d     = ev_q;
    nrow_d   = nrow_q;
    orow_d   = orow_q;
    ex_wr_en = 1'b0;
    capture  = 1'b0;
    case (req_q)
      kmsr_pkg::REQ_READ: begin
        case (reg_q)
          kmsr_pkg::REG_CTRL: begin
            res_rd = {ctrl_q, ev_q[1], ev_q[1] ^ ev_q[0]};
          end
          kmsr_pkg::REG_SCAN: begin
            res_rd = scan_q;
          end
          kmsr_pkg::REG_NEW, kmsr_pkg::REG_OLD: begin
            if (!enabled) begin
              res_rd = kmsr_pkg::ROW_IDLE;
            end else begin
              res_rd = port_field;
              if (port_next >= {1'b0, drive_cnt}) begin
                if (ev_q != 2'd0) begin
                  res_err = kmsr_pkg::ERR_BURST_END;
                end
                if (reg_q == kmsr_pkg::REG_NEW) begin
                  nrow_d = '0;
                end else begin
                  orow_d = '0;
                end
              end else if (reg_q == kmsr_pkg::REG_NEW) begin
                nrow_d = port_next[IW-1:0];
              end else begin
                orow_d = port_next[IW-1:0];
              end
            end
          end
          default: begin
            res_err = kmsr_pkg::ERR_BAD_REG;
          end
        endcase
      end
      kmsr_pkg::REQ_WRITE: begin
        case (reg_q)
          kmsr_pkg::REG_CTRL: begin
            ctrl_d = wd_q[7:2];
            if (!enabled && wd_q[kmsr_pkg::CTRL_ENABLE_BIT] &&
                (nrow_q != '0 || orow_q != '0)) begin
              res_err = kmsr_pkg::ERR_EN_MID_BURST;
            end
          end
          kmsr_pkg::REG_SCAN: begin
            if (wd_q[kmsr_pkg::SCAN_RD_STATE]) begin
              res_err = kmsr_pkg::ERR_SCAN_RD_STATE;
            end else begin
              scan_d = wd_q;
            end
          end
          default: begin
            res_err = kmsr_pkg::ERR_BAD_REG;
          end
        endcase
      end
      kmsr_pkg::REQ_KEY: begin
        if (!key_ok) begin
          res_err = kmsr_pkg::ERR_KEY_RANGE;
        end else if (key_after != key_row) begin
          ex_wr_en = 1'b1;
          if (enabled) begin
            capture = 1'b1;
            res_irq = 1'b1;
            if (ev_q != kmsr_pkg::EVENTS_MAX) begin
              ev_d = ev_q + 1'b1;
            end
          end
        end
      end
      default: begin
        res_err = kmsr_pkg::ERR_BAD_REG;
      end
    endcase
  end

  always_comb begin
    if (state_q == ST_SWEEP) begin
      ram_req = sweep.ram;
    end else begin
      ram_req.rd_en   = acc_rd_en;
      ram_req.rd_addr = acc_addr;
      ram_req.wr_en   = exec && ex_wr_en;
      ram_req.wr_addr = drv_q;
      ram_req.wr_data = {key_after, new_row, old_row};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = capture ? ST_SWEEP : ST_IDLE;
      end
      ST_SWEEP: begin
        if (sweep.done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  kmsr_ram #(
    .Width (kmsr_pkg::WORD_W),
    .Depth (kmsr_pkg::MAX_ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.wr_en),
    .waddr_i (ram_req.wr_addr),
    .wdata_i (ram_req.wr_data),
    .re_i    (ram_req.rd_en),
    .raddr_i (ram_req.rd_addr),
    .rdata_o (ram_rdata)
  );

  kmsr_sweep u_sweep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (exec && capture),
    .rd_word_i (rd_word),
    .sweep_o   (sweep)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ctrl_q    <= '0;
      scan_q    <= '0;
      ev_q      <= '0;
      nrow_q    <= '0;
      orow_q    <= '0;
      valid_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec) begin
        ctrl_q <= ctrl_d;
        scan_q <= scan_d;
        ev_q   <= ev_d;
        nrow_q <= nrow_d;
        orow_q <= orow_d;
      end
      if (ram_req.wr_en) begin
        valid_q[ram_req.wr_addr] <= 1'b1;
      end
      if (exec) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      req_q  <= kmsr_pkg::req_e'(s_axis_tdata_i[1:0]);
      reg_q  <= s_axis_tdata_i[4:2];
      wd_q   <= s_axis_tdata_i[12:5];
      drv_q  <= s_axis_tdata_i[17:13];
      sns_q  <= s_axis_tdata_i[20:18];
      down_q <= s_axis_tdata_i[21];
    end
    if (ram_req.rd_en) begin
      rd_addr_q <= ram_req.rd_addr;
    end
    if (exec) begin
      m_data_q <= {4'b0000, res_err, res_irq, res_rd};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_rw_same_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.wr_en && ram_req.rd_en |-> ram_req.wr_addr != ram_req.rd_addr)
    else $error("row ram read and written at the same row");

  a_out_free_on_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> !m_valid_q)
    else $error("result register still full when a result is produced");

  a_irq_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && res_irq |=> state_q == ST_SWEEP)
    else $error("capture without row sweep");

  a_events_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_q != 2'd0 |=> ev_q >= $past(ev_q))
    else $error("event count went down");
`endif

endmodule

### tb/keypad_matrix_scan_registers_test.sv
module keypad_matrix_scan_registers_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kmsr_pkg::*;

  localparam logic [1:0] REQ_BAD         = 2'd3;
  localparam logic [2:0] REG_UNUSED      = 3'd4;
  localparam logic [2:0] REG_LAST        = 3'd7;
  localparam logic [7:0] CTRL_EVENT_BITS = 8'h03;
  localparam logic       TYPED           = 1'b1;
  localparam logic       PREDICT         = 1'b0;
  localparam int         RANDOM_BEATS    = 1920;
  localparam int         DRAIN_CYCLES    = 40;

  // one request beat, last field in the lowest bits
  typedef struct packed {
    logic       key_down;
    logic [2:0] sense_line;
    logic [4:0] drive_line;
    logic [7:0] write_data;
    logic [2:0] reg_sel;
    logic [1:0] req_type;
  } key_req_t;

  typedef struct packed {
    logic [2:0] error_code;
    logic       irq_pulse;
    logic [7:0] read_data;
  } scan_result_t;

  typedef struct packed {
    key_req_t     q;
    logic         fixed;
    scan_result_t want;
  } script_row_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  // scanner state as the block should hold it
  logic [7:0] ctrl_q;
  logic [7:0] scan_q;
  logic [7:0] key_matrix [MAX_ROWS];
  logic [7:0] new_snap   [MAX_ROWS];
  logic [7:0] old_snap   [MAX_ROWS];
  logic [1:0] events;
  logic [4:0] new_idx;
  logic [4:0] old_idx;

  scan_result_t expectations [$];
  key_req_t     pending [$];
  script_row_t  steps [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int beats_sent = 0;
  int directed_beats = 0;
  int random_sent = 0;
  int results_checked = 0;
  int captures = 0;
  int mismatches = 0;
  logic [7:0] codes_seen = '0;

  keypad_matrix_scan_registers DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic int drive_lines(input logic [2:0] code);
    case (code)
      3'd0:    return 5;
      3'd1:    return 6;
      3'd2:    return 7;
      3'd3:    return 8;
      3'd4:    return 10;
      3'd5:    return 12;
      3'd6:    return 15;
      default: return 18;
    endcase
  endfunction

  function automatic int sense_lines(input logic [1:0] code);
    return 5 + int'(code);
  endfunction

  // applies one request to the state copy and returns the result it should give
  function automatic scan_result_t scan_predict(input key_req_t q);
    scan_result_t res;
    int           dcount;
    int           scount;
    int           nxt;
    logic [4:0]   idx;
    logic [7:0]   row;
    logic         was_on;
    res = '0;
    dcount = drive_lines(ctrl_q[4:2]);
    scount = sense_lines(ctrl_q[6:5]);
    case (q.req_type)
      REQ_READ: begin
        case (q.reg_sel)
          REG_CTRL: res.read_data = (ctrl_q & ~CTRL_EVENT_BITS) | {6'd0, events ^ (events >> 1)};
          REG_SCAN: res.read_data = scan_q;
          REG_NEW, REG_OLD: begin
            if (!ctrl_q[CTRL_ENABLE_BIT]) begin
              res.read_data = ROW_IDLE;
            end else begin
              idx = (q.reg_sel == REG_OLD) ? old_idx : new_idx;
              if (idx >= MAX_ROWS) begin
                res.read_data = ROW_IDLE;
              end else begin
                res.read_data = (q.reg_sel == REG_OLD) ? old_snap[idx] : new_snap[idx];
              end
              nxt = int'(idx) + 1;
              // wrap may sit below the index if the drive count was lowered
              if (nxt >= dcount) begin
                nxt = 0;
                if (events != 2'd0) res.error_code = ERR_BURST_END;
              end
              if (q.reg_sel == REG_OLD) old_idx = 5'(nxt);
              else new_idx = 5'(nxt);
            end
          end
          default: res.error_code = ERR_BAD_REG;
        endcase
      end
      REQ_WRITE: begin
        case (q.reg_sel)
          REG_CTRL: begin
            was_on = ctrl_q[CTRL_ENABLE_BIT];
            ctrl_q = q.write_data & ~CTRL_EVENT_BITS;
            if (!was_on && ctrl_q[CTRL_ENABLE_BIT] && (new_idx != 5'd0 || old_idx != 5'd0)) begin
              res.error_code = ERR_EN_MID_BURST;
            end
          end
          REG_SCAN: begin
            if (q.write_data[SCAN_RD_STATE]) res.error_code = ERR_SCAN_RD_STATE;
            else scan_q = q.write_data;
          end
          default: res.error_code = ERR_BAD_REG;
        endcase
      end
      REQ_KEY: begin
        if (int'(q.drive_line) >= dcount || int'(q.sense_line) >= scount ||
            q.drive_line >= MAX_ROWS) begin
          res.error_code = ERR_KEY_RANGE;
        end else begin
          row = key_matrix[q.drive_line];
          row[q.sense_line] = !q.key_down;
          if (row != key_matrix[q.drive_line]) begin
            key_matrix[q.drive_line] = row;
            if (ctrl_q[CTRL_ENABLE_BIT]) begin
              for (int i = 0; i < MAX_ROWS; i++) begin
                old_snap[i] = new_snap[i];
                new_snap[i] = key_matrix[i];
              end
              if (events != EVENTS_MAX) events = events + 2'd1;
              res.irq_pulse = 1'b1;
            end
          end
        end
      end
      default: res.error_code = ERR_BAD_REG;
    endcase
    return res;
  endfunction

  // appends one row to the directed table
  function automatic void add_row(input logic [1:0] req, input logic [2:0] sel,
                                  input logic [7:0] wd, input logic [4:0] drv,
                                  input logic [2:0] sns, input logic dn,
                                  input logic fixed, input logic [7:0] rd,
                                  input logic irq, input logic [2:0] err);
    script_row_t r;
    r.q.req_type        = req;
    r.q.reg_sel         = sel;
    r.q.write_data      = wd;
    r.q.drive_line      = drv;
    r.q.sense_line      = sns;
    r.q.key_down        = dn;
    r.fixed             = fixed;
    r.want.read_data    = rd;
    r.want.irq_pulse    = irq;
    r.want.error_code   = err;
    steps.push_back(r);
  endfunction

  // queues the next stretch of random requests, shaped by the current settings
  task automatic plan_random();
    key_req_t q;
    int       pick;
    int       dcount;
    int       scount;
    int       n;
    pick = $urandom_range(99);
    dcount = drive_lines(ctrl_q[4:2]);
    scount = sense_lines(ctrl_q[6:5]);
    q = 22'($urandom);
    if (pick < 35) begin
      q.req_type = REQ_KEY;
      q.drive_line = 5'($urandom_range(dcount - 1));
      q.sense_line = 3'($urandom_range(scount - 1));
      pending.push_back(q);
    end else if (pick < 50) begin
      // a key change, then a sweep of the new-data port and maybe the old-data port
      q.req_type = REQ_KEY;
      q.drive_line = 5'($urandom_range(dcount - 1));
      q.sense_line = 3'($urandom_range(scount - 1));
      q.key_down = key_matrix[q.drive_line][q.sense_line];
      pending.push_back(q);
      n = ($urandom_range(1) != 0) ? dcount : 2 * dcount;
      for (int i = 0; i < n; i++) begin
        q = 22'($urandom);
        q.req_type = REQ_READ;
        q.reg_sel = (i < dcount) ? REG_NEW : REG_OLD;
        pending.push_back(q);
      end
    end else if (pick < 65) begin
      q.req_type = REQ_READ;
      q.reg_sel = ($urandom_range(1) != 0) ? REG_NEW : REG_OLD;
      pending.push_back(q);
    end else if (pick < 75) begin
      q.req_type = REQ_WRITE;
      q.reg_sel = REG_CTRL;
      q.write_data[CTRL_ENABLE_BIT] = ($urandom_range(99) < 80);
      pending.push_back(q);
    end else if (pick < 82) begin
      q.req_type = REQ_WRITE;
      q.reg_sel = REG_SCAN;
      pending.push_back(q);
    end else if (pick < 88) begin
      q.req_type = REQ_READ;
      q.reg_sel = ($urandom_range(1) != 0) ? REG_CTRL : REG_SCAN;
      pending.push_back(q);
    end else begin
      // any request type, any register, any line
      pending.push_back(q);
    end
  endtask

  task automatic send_beat(input key_req_t q, input logic fixed, input scan_result_t fixed_want);
    int           gap;
    scan_result_t want;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, q};
    do @(posedge clk_i); while (!s_tready);
    want = scan_predict(q);
    expectations.push_back(fixed ? fixed_want : want);
    beats_sent++;
  endtask

  always @(posedge clk_i) begin : result_check
    scan_result_t got;
    scan_result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = scan_result_t'(m_tdata[11:0]);
      if (expectations.size() == 0) begin
        $display("%0t: result beat %h arrived with nothing expected", $time, got);
        mismatches++;
      end else begin
        want = expectations.pop_front();
        results_checked++;
        if (got.read_data !== want.read_data) begin
          $display("%0t: read_data expected %h, got %h", $time, want.read_data, got.read_data);
          mismatches++;
        end
        if (got.irq_pulse !== want.irq_pulse) begin
          $display("%0t: irq_pulse expected %b, got %b", $time, want.irq_pulse, got.irq_pulse);
          mismatches++;
        end
        if (got.error_code !== want.error_code) begin
          $display("%0t: error_code expected %0d, got %0d", $time, want.error_code,
                   got.error_code);
          mismatches++;
        end
        if (got.irq_pulse === 1'b1) captures++;
        if (!$isunknown(got.error_code)) codes_seen[got.error_code] = 1'b1;
      end
    end
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin : stimulus
    int          phase;
    ctrl_q = '0;
    scan_q = '0;
    events = '0;
    new_idx = '0;
    old_idx = '0;
    for (int i = 0; i < MAX_ROWS; i++) begin
      key_matrix[i] = ROW_IDLE;
      new_snap[i] = ROW_IDLE;
      old_snap[i] = ROW_IDLE;
    end

    //      req        reg         wdata  drive  sense dn    check    rd     irq   err
    add_row(REQ_READ,  REG_CTRL,   8'h00, 5'd0,  3'd0, 1'b0, TYPED,   8'h00, 1'b0, ERR_OK);
    add_row(REQ_READ,  REG_NEW,    8'h00, 5'd0,  3'd0, 1'b0, TYPED,   8'hFF, 1'b0, ERR_OK);
    add_row(REQ_READ,  REG_UNUSED, 8'h00, 5'd0,  3'd0, 1'b0, TYPED,   8'h00, 1'b0, ERR_BAD_REG);
    add_row(REQ_WRITE, REG_NEW,    8'h5A, 5'd0,  3'd0, 1'b0, TYPED,   8'h00, 1'b0, ERR_BAD_REG);
    add_row(REQ_BAD,   REG_LAST,   8'hFF, 5'd31, 3'd7, 1'b1, TYPED,   8'h00, 1'b0, ERR_BAD_REG);
    add_row(REQ_WRITE, REG_SCAN,   8'h01, 5'd0,  3'd0, 1'b0, TYPED,   8'h00, 1'b0,
            ERR_SCAN_RD_STATE);
    add_row(REQ_WRITE, REG_SCAN,   8'hFE, 5'd0,  3'd0, 1'b0, TYPED,   8'h00, 1'b0, ERR_OK);
    add_row(REQ_READ,  REG_SCAN,   8'h00, 5'd0,  3'd0, 1'b0, TYPED,   8'hFE, 1'b0, ERR_OK);
    // key change while disabled: matrix only
    add_row(REQ_KEY,   REG_CTRL,   8'h00, 5'd4,  3'd4, 1'b1, TYPED,   8'h00, 1'b0, ERR_OK);
    add_row(REQ_KEY,   REG_CTRL,   8'h00, 5'd5,  3'd0, 1'b1, TYPED,   8'h00, 1'b0, ERR_KEY_RANGE);
    add_row(REQ_KEY,   REG_CTRL,   8'h00, 5'd0,  3'd5, 1'b1, TYPED,   8'h00, 1'b0, ERR_KEY_RANGE);
    add_row(REQ_WRITE, REG_CTRL,   8'hFF, 5'd0,  3'd0, 1'b0, TYPED,   8'h00, 1'b0, ERR_OK);
    add_row(REQ_READ,  REG_CTRL,   8'h00, 5'd0,  3'd0, 1'b0, TYPED,   8'hFC, 1'b0, ERR_OK);
    add_row(REQ_KEY,   REG_CTRL,   8'h00, 5'd17, 3'd7, 1'b1, TYPED,   8'h00, 1'b1, ERR_OK);
    // same key again: no change, no capture
    add_row(REQ_KEY,   REG_CTRL,   8'h00, 5'd17, 3'd7, 1'b1, TYPED,   8'h00, 1'b0, ERR_OK);
    add_row(REQ_KEY,   REG_CTRL,   8'h00, 5'd31, 3'd0, 1'b0, TYPED,   8'h00, 1'b0, ERR_KEY_RANGE);
    add_row(REQ_READ,  REG_CTRL,   8'h00, 5'd0,  3'd0, 1'b0, TYPED,   8'hFD, 1'b0, ERR_OK);
    add_row(REQ_READ,  REG_NEW,    8'h00, 5'd0,  3'd0, 1'b0, PREDICT, 8'h00, 1'b0, ERR_OK);
    add_row(REQ_READ,  REG_NEW,    8'h00, 5'd0,  3'd0, 1'b0, PREDICT, 8'h00, 1'b0, ERR_OK);
    add_row(REQ_READ,  REG_NEW,    8'h00, 5'd0,  3'd0, 1'b0, PREDICT, 8'h00, 1'b0, ERR_OK);
    add_row(REQ_READ,  REG_NEW,    8'h00, 5'd0,  3'd0, 1'b0, PREDICT, 8'h00, 1'b0, ERR_OK);
    add_row(REQ_READ,  REG_NEW,    8'h00, 5'd0,  3'd0, 1'b0, PREDICT, 8'h00, 1'b0, ERR_OK);
    add_row(REQ_READ,  REG_NEW,    8'h00, 5'd0,  3'd0, 1'b0, PREDICT, 8'h00, 1'b0, ERR_OK);
    // drive count lowered under the read index: row is read, then the index wraps
    add_row(REQ_WRITE, REG_CTRL,   8'h80, 5'd0,  3'd0, 1'b0, TYPED,   8'h00, 1'b0, ERR_OK);
    add_row(REQ_READ,  REG_NEW,    8'h00, 5'd0,  3'd0, 1'b0, TYPED,   8'hFF, 1'b0, ERR_BURST_END);
    add_row(REQ_READ,  REG_OLD,    8'h00, 5'd0,  3'd0, 1'b0, PREDICT, 8'h00, 1'b0, ERR_OK);
    add_row(REQ_WRITE, REG_CTRL,   8'h00, 5'd0,  3'd0, 1'b0, TYPED,   8'h00, 1'b0, ERR_OK);
    add_row(REQ_WRITE, REG_CTRL,   8'h80, 5'd0,  3'd0, 1'b0, TYPED,   8'h00, 1'b0,
            ERR_EN_MID_BURST);
    add_row(REQ_KEY,   REG_CTRL,   8'h00, 5'd4,  3'd4, 1'b0, TYPED,   8'h00, 1'b1, ERR_OK);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[k]) send_beat(steps[k].q, steps[k].fixed, steps[k].want);
    directed_beats = beats_sent;

    for (phase = 0; phase < 4; phase++) begin
      // hold off until the block has drained before the idling pattern changes
      s_tvalid <= 1'b0;
      @(posedge clk_i);
      while (expectations.size() != 0) @(posedge clk_i);
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      while (random_sent < (phase + 1) * RANDOM_BEATS / 4) begin
        if (pending.size() == 0) plan_random();
        send_beat(pending.pop_front(), PREDICT, '0);
        random_sent++;
      end
    end

    s_tvalid <= 1'b0;
    stall_pct = 0;
    while (expectations.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d request beats (%0d from the directed table), %0d results checked",
             beats_sent, directed_beats, results_checked);
    $display("captures seen: %0d, error codes returned (one bit per code): %b",
             captures, codes_seen);
    if (mismatches == 0 && expectations.size() == 0) begin
      $display("keypad_matrix_scan_registers_test: PASS");
    end else begin
      $display("keypad_matrix_scan_registers_test: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results still expected", expectations.size());
    $display("keypad_matrix_scan_registers_test: FAIL");
    $finish;
  end

endmodule

### keypad_matrix_scan_registers.f
rtl/kmsr_pkg.sv
rtl/kmsr_ram.sv
rtl/kmsr_sweep.sv
rtl/keypad_matrix_scan_registers.sv
tb/keypad_matrix_scan_registers_test.sv
